// ===== hdl/jmsc_pkg.sv =====
// Package for the JPEG marker structure checker: phase and verdict codes, parser state.
`default_nettype none

package jmsc_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HDR0  = 4'd0,
    PH_HDR1  = 4'd1,
    PH_HUNT  = 4'd2,
    PH_MARK  = 4'd3,
    PH_LENHI = 4'd4,
    PH_LENLO = 4'd5,
    PH_SKIP  = 4'd6,
    PH_SCAN  = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  // Verdict codes
  typedef enum logic [2:0] {
    V_OK     = 3'd0,
    V_SHORT  = 3'd1,
    V_NOSOI  = 3'd2,
    V_TRUNC  = 3'd3,
    V_BADLEN = 3'd4,
    V_NOSOS  = 3'd5,
    V_NOEOI  = 3'd6
  } verdict_t;

  // Marker byte values
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] BYTE_SOS = 8'hDA;
  localparam logic [7:0] BYTE_STUFF = 8'h00;

  // Byte count saturates here; files below SHORT_LIMIT bytes are too short
  localparam logic [2:0] COUNT_MAX   = 3'd7;
  localparam logic [2:0] SHORT_LIMIT = 3'd4;

  // Parser state carried between bytes (settled means phase == PH_DONE)
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  byte_count;
    logic        soi_bad;
    logic [7:0]  length_high;
    logic [15:0] skip_remaining;
    logic        sos_seen;
    logic        prev_was_ff;
    verdict_t    settled_verdict;
  } parse_state_t;

  localparam parse_state_t STATE_INIT = '{
    phase:           PH_HDR0,
    byte_count:      3'd0,
    soi_bad:         1'b0,
    length_high:     8'd0,
    skip_remaining:  16'd0,
    sos_seen:        1'b0,
    prev_was_ff:     1'b0,
    settled_verdict: V_OK
  };

  // Result of one byte step
  typedef struct packed {
    parse_state_t state;
    verdict_t     verdict;
  } step_out_t;

endpackage

`default_nettype wire

// ===== hdl/jmsc_step.sv =====
// Per-byte next-state and verdict logic of the JPEG marker structure checker.
`default_nettype none

module jmsc_step (
  input  wire jmsc_pkg::parse_state_t cur,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  output jmsc_pkg::step_out_t         res
);

  jmsc_pkg::parse_state_t nxt;
  logic [15:0]            seg_len;
  jmsc_pkg::verdict_t     end_v;

  assign seg_len = {cur.length_high, data_byte};

  // Byte-level parse
  always_comb begin
    nxt = cur;
    if (cur.byte_count != jmsc_pkg::COUNT_MAX) begin
      nxt.byte_count = cur.byte_count + 3'd1;
    end
    unique case (cur.phase)
      jmsc_pkg::PH_HDR0: begin
        if (data_byte != jmsc_pkg::BYTE_FF) nxt.soi_bad = 1'b1;
        nxt.phase = jmsc_pkg::PH_HDR1;
      end
      jmsc_pkg::PH_HDR1: begin
        if (cur.soi_bad || data_byte != jmsc_pkg::BYTE_SOI) begin
          nxt.soi_bad         = 1'b1;
          nxt.settled_verdict = jmsc_pkg::V_NOSOI;
          nxt.phase           = jmsc_pkg::PH_DONE;
        end else begin
          nxt.phase = jmsc_pkg::PH_HUNT;
        end
      end
      jmsc_pkg::PH_HUNT: begin
        if (data_byte == jmsc_pkg::BYTE_FF) nxt.phase = jmsc_pkg::PH_MARK;
      end
      jmsc_pkg::PH_MARK: begin
        if (data_byte == jmsc_pkg::BYTE_STUFF) begin
          nxt.phase = jmsc_pkg::PH_HUNT;
        end else if (data_byte == jmsc_pkg::BYTE_EOI) begin
          nxt.settled_verdict = cur.sos_seen ? jmsc_pkg::V_OK : jmsc_pkg::V_NOSOS;
          nxt.phase           = jmsc_pkg::PH_DONE;
        end else if (data_byte == jmsc_pkg::BYTE_SOS) begin
          nxt.sos_seen    = 1'b1;
          nxt.prev_was_ff = 1'b0;
          nxt.phase       = jmsc_pkg::PH_SCAN;
        end else begin
          nxt.phase = jmsc_pkg::PH_LENHI;
        end
      end
      jmsc_pkg::PH_LENHI: begin
        nxt.length_high = data_byte;
        nxt.phase       = jmsc_pkg::PH_LENLO;
      end
      jmsc_pkg::PH_LENLO: begin
        // lengths of 0 or 1 cannot cover the length field itself
        if (seg_len < 16'd2) begin
          nxt.settled_verdict = jmsc_pkg::V_BADLEN;
          nxt.phase           = jmsc_pkg::PH_DONE;
        end else begin
          nxt.skip_remaining = seg_len - 16'd2;
          nxt.phase = (seg_len != 16'd2) ? jmsc_pkg::PH_SKIP : jmsc_pkg::PH_HUNT;
        end
      end
      jmsc_pkg::PH_SKIP: begin
        nxt.skip_remaining = cur.skip_remaining - 16'd1;
        if (cur.skip_remaining == 16'd1) nxt.phase = jmsc_pkg::PH_HUNT;
      end
      jmsc_pkg::PH_SCAN: begin
        if (cur.prev_was_ff && data_byte == jmsc_pkg::BYTE_EOI) begin
          nxt.settled_verdict = jmsc_pkg::V_OK;
          nxt.phase           = jmsc_pkg::PH_DONE;
        end else begin
          nxt.prev_was_ff = (data_byte == jmsc_pkg::BYTE_FF);
        end
      end
      default: begin
        // settled: bytes are ignored until the final one
      end
    endcase
  end

  // Verdict when the file ends: from the phase if unsettled, else the settled verdict
  always_comb begin
    unique case (nxt.phase)
      jmsc_pkg::PH_LENHI, jmsc_pkg::PH_LENLO: end_v = jmsc_pkg::V_TRUNC;
      jmsc_pkg::PH_SCAN:                      end_v = jmsc_pkg::V_NOEOI;
      jmsc_pkg::PH_HDR0, jmsc_pkg::PH_HDR1:   end_v = jmsc_pkg::V_SHORT;
      jmsc_pkg::PH_DONE:                      end_v = nxt.settled_verdict;
      default:                                end_v = jmsc_pkg::V_NOSOS;
    endcase
  end

  // Final byte reports and returns the parser to its reset state
  always_comb begin
    if (nxt.byte_count < jmsc_pkg::SHORT_LIMIT) begin
      res.verdict = jmsc_pkg::V_SHORT;
    end else begin
      res.verdict = end_v;
    end
    res.state = last_byte ? jmsc_pkg::STATE_INIT : nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/jpeg_marker_structure_checker.sv =====
// Top level of the JPEG marker structure checker: stream ports, parser state and result register.
`default_nettype none

// Takes one file byte per input transaction (in_tlast on the final byte) and returns one
// verdict transaction per file, after its final byte. A byte is taken every cycle while input
// is not stalled: the parser state is registered from short logic on the accepted byte, and the
// verdict lands in an output register in the cycle after the final byte. The only stall is
// a verdict still waiting in that register while out_tready is low; input then holds off
// until it is taken. out_tdata[2:0] is the verdict code, out_tdata[3] is high for ok.
module jpeg_marker_structure_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [2:0] verdict, [3] structure_ok, [7:4] zero
);

  jmsc_pkg::parse_state_t state_r;
  jmsc_pkg::step_out_t    step;
  logic                   out_valid_r;
  logic [7:0]             out_data_r;
  logic                   in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  jmsc_step u_step (
    .cur       (state_r),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .res       (step)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jmsc_pkg::STATE_INIT;
    end else if (in_fire) begin
      state_r <= step.state;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_data_r <= {4'd0, (step.verdict == jmsc_pkg::V_OK), step.verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/jmsc_checker.sv =====
// Port-level assertions for the JPEG marker structure checker and their bind.
`default_nettype none

module jmsc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // A stalled verdict holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled verdict changed");

  // ok flag agrees with the verdict code, and the code is in range
  a_ok_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] == (out_tdata[2:0] == jmsc_pkg::V_OK))
                   && (out_tdata[2:0] <= jmsc_pkg::V_NOEOI)
                   && (out_tdata[7:4] == 4'd0))
    else $error("verdict and ok flag disagree");

  // A new verdict only follows an accepted final byte
  a_verdict_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("verdict without final byte");

  // Every accepted final byte yields a verdict in the next cycle
  a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("final byte gave no verdict");

  // Input stalls only while a verdict waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting verdict");

endmodule

bind jpeg_marker_structure_checker jmsc_checker u_jmsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
